// ===== rtl/udpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// udpcs_pkg: shared types, constants and arithmetic helpers
// Constants of the UDP/IPv4 checksum datapath and the one's-complement fold.
// ----------------------------------------------------------------------------
`default_nettype none

package udpcs_pkg;

	localparam logic [15:0] PROTO_UDP      = 16'd17;
	localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
	localparam logic [15:0] LEN_MAX        = 16'hFFFF;

	// Control of the accumulator for the word held in stage one.
	typedef struct packed {
		logic step;         // the word in stage one is consumed this cycle
		logic single_byte;  // only the upper byte is valid
		logic last;         // the word ends the segment
	} acc_ctrl_t;

	// Folds a sum of up to eight 16-bit terms into a 16-bit one's-complement
	// value. A zero sum stays zero and any other sum lands in 1..0xFFFF.
	function automatic logic [15:0] ones_fold(input logic [18:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {14'b0, s[18:16]};
		return t[15:0] + {15'b0, t[16]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/udpcs_in_if.sv =====
// ----------------------------------------------------------------------------
// udpcs_in_if: segment word channel
// Valid/ready channel that carries one segment word and the IPv4 addresses.
// ----------------------------------------------------------------------------
`default_nettype none

interface udpcs_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;
	logic        single_byte;
	logic        last;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;

	modport source (
		output valid, data_word, single_byte, last, src_ip, dst_ip,
		input  ready
	);

	modport sink (
		input  valid, data_word, single_byte, last, src_ip, dst_ip,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/udpcs_out_if.sv =====
// ----------------------------------------------------------------------------
// udpcs_out_if: checksum result channel
// Valid/ready channel that carries the checksum and the counted length.
// ----------------------------------------------------------------------------
`default_nettype none

interface udpcs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic [15:0] seg_length;
	logic        too_long;

	modport source (
		output valid, checksum, seg_length, too_long,
		input  ready
	);

	modport sink (
		input  valid, checksum, seg_length, too_long,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/udpcs_hdr_sum.sv =====
// ----------------------------------------------------------------------------
// udpcs_hdr_sum: pseudo-header address sum
// Folds both IPv4 addresses and the protocol number into one 16-bit term.
// ----------------------------------------------------------------------------
`default_nettype none

module udpcs_hdr_sum (
	input  wire logic [31:0] src_ip,
	input  wire logic [31:0] dst_ip,
	output logic      [15:0] hdr_sum
);
	import udpcs_pkg::*;

	logic [18:0] raw_sum;

	always_comb begin
		raw_sum = {3'b0, src_ip[31:16]} + {3'b0, src_ip[15:0]}
		        + {3'b0, dst_ip[31:16]} + {3'b0, dst_ip[15:0]}
		        + {3'b0, PROTO_UDP};
		hdr_sum = ones_fold(raw_sum);
	end

endmodule

`default_nettype wire

// ===== rtl/udpcs_accum.sv =====
// ----------------------------------------------------------------------------
// udpcs_accum: running sum and length counter
// Holds the per-segment state and forms the final checksum on the last word.
// ----------------------------------------------------------------------------
`default_nettype none

module udpcs_accum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire udpcs_pkg::acc_ctrl_t  ctrl,
	input  wire logic [15:0]           data_word,
	input  wire logic [15:0]           hdr_sum,
	output logic      [15:0]           checksum,
	output logic      [15:0]           seg_length,
	output logic                       too_long
);
	import udpcs_pkg::*;

	logic [15:0] sum_q;
	logic [15:0] count_q;
	logic        ovf_q;

	logic [15:0] word_m;
	logic [15:0] sum_nxt;
	logic [16:0] count_raw;
	logic [15:0] count_nxt;
	logic        ovf_nxt;
	logic [15:0] total;

	always_comb begin
		word_m    = ctrl.single_byte ? (data_word & HIGH_BYTE_MASK) : data_word;
		sum_nxt   = ones_fold({3'b0, sum_q} + {3'b0, word_m});
		count_raw = {1'b0, count_q} + (ctrl.single_byte ? 17'd1 : 17'd2);
		// The length saturates rather than wrapping.
		count_nxt = count_raw[16] ? LEN_MAX : count_raw[15:0];
		ovf_nxt   = ovf_q | count_raw[16];
		total     = ones_fold({3'b0, sum_nxt} + {3'b0, hdr_sum} + {3'b0, count_nxt});
		checksum   = ~total;
		seg_length = count_nxt;
		too_long   = ovf_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				sum_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= sum_nxt;
				count_q <= count_nxt;
				ovf_q   <= ovf_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/udpcs_out_reg.sv =====
// ----------------------------------------------------------------------------
// udpcs_out_reg: result register
// Holds one checksum result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module udpcs_out_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [15:0] checksum,
	input  wire logic [15:0] seg_length,
	input  wire logic        too_long,
	output logic             free,
	udpcs_out_if.source      res
);
	import udpcs_pkg::*;

	logic        valid_q;
	logic [15:0] checksum_q;
	logic [15:0] length_q;
	logic        too_long_q;

	assign free           = !valid_q || res.ready;
	assign res.valid      = valid_q;
	assign res.checksum   = checksum_q;
	assign res.seg_length = length_q;
	assign res.too_long   = too_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			checksum_q <= checksum;
			length_q   <= seg_length;
			too_long_q <= too_long;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/udpcs_top_guard.sv =====
// ----------------------------------------------------------------------------
// udpcs_top_guard: stage-one advance control
// Decides when the word held in stage one is consumed by the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module udpcs_top_guard (
	input  wire logic valid_s1,
	input  wire logic last_s1,
	input  wire logic single_s1,
	input  wire logic out_free,
	output udpcs_pkg::acc_ctrl_t ctrl,
	output logic      load_out,
	output logic      in_ready
);
	import udpcs_pkg::*;

	always_comb begin
		// A word that ends the segment waits for room in the result register.
		ctrl.step        = valid_s1 && (!last_s1 || out_free);
		ctrl.single_byte = single_s1;
		ctrl.last        = last_s1;
		load_out         = ctrl.step && last_s1;
		in_ready         = !valid_s1 || ctrl.step;
	end

endmodule

`default_nettype wire

// ===== rtl/udp_ipv4_checksum_core.sv =====
// ----------------------------------------------------------------------------
// udp_ipv4_checksum_core: UDP over IPv4 checksum engine
// Accumulates a UDP segment and emits its RFC 768 pseudo-header checksum.
// ----------------------------------------------------------------------------
// The block takes one 16-bit big-endian segment word per clock and returns one
// result per segment, loaded into the result register when the word marked
// last leaves stage one. Each word passes an input register (stage one), where
// the pseudo-header address sum is already folded, and then a single
// end-around-carry add into the running sum; that add and the final three-term
// fold set the clock path. The result register decouples the sides: words keep
// flowing while a result waits, and input stalls only when a second last word
// finds the result still untaken. The length saturates at 65535 with too_long
// set, and a computed zero checksum is emitted as 0x0000.
`default_nettype none

module udp_ipv4_checksum_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	udpcs_in_if.sink    pkt,
	udpcs_out_if.source res
);
	import udpcs_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        single_s1;
	logic        last_s1;
	logic [15:0] hdr_s1;

	logic [15:0] hdr_sum;
	logic [15:0] checksum;
	logic [15:0] seg_length;
	logic        too_long;
	logic        out_free;
	logic        load_out;
	acc_ctrl_t   ctrl;

	udpcs_hdr_sum u_hdr (
		.src_ip  (pkt.src_ip),
		.dst_ip  (pkt.dst_ip),
		.hdr_sum (hdr_sum)
	);

	udpcs_top_guard u_guard (
		.valid_s1  (valid_s1),
		.last_s1   (last_s1),
		.single_s1 (single_s1),
		.out_free  (out_free),
		.ctrl      (ctrl),
		.load_out  (load_out),
		.in_ready  (pkt.ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (ctrl.step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			word_s1   <= pkt.data_word;
			single_s1 <= pkt.single_byte;
			last_s1   <= pkt.last;
			hdr_s1    <= hdr_sum;
		end
	end

	udpcs_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.data_word  (word_s1),
		.hdr_sum    (hdr_s1),
		.checksum   (checksum),
		.seg_length (seg_length),
		.too_long   (too_long)
	);

	udpcs_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_out),
		.checksum   (checksum),
		.seg_length (seg_length),
		.too_long   (too_long),
		.free       (out_free),
		.res        (res)
	);

	// A segment end that is consumed must show up as a result transaction.
	a_result_follows_last: assert property (
		@(posedge clk) disable iff (!arst_n)
		(ctrl.step && last_s1) |=> res.valid
	) else $error("last word consumed without a result");

	// Input only stalls when a finished segment is blocked by a pending result.
	a_stall_reason: assert property (
		@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> (valid_s1 && last_s1 && res.valid && !res.ready)
	) else $error("input stalled without a blocked result");

	// A saturated length is always reported as the maximum value.
	a_too_long_len: assert property (
		@(posedge clk) disable iff (!arst_n)
		(res.valid && res.too_long) |-> (res.seg_length == LEN_MAX)
	) else $error("too_long set with unsaturated length");

endmodule

`default_nettype wire

// ===== tb/udp_ipv4_checksum_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_ipv4_checksum_core_test: checksum engine testbench
// Streams directed and random UDP segments through the engine and compares
// each checksum, length and overflow flag with a one's-complement model of
// the segment sum plus the IPv4 pseudo-header, under varied idling.
// ----------------------------------------------------------------------------

module udp_ipv4_checksum_core_test;
	import udpcs_pkg::*;

	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int WORDS_PER_PHASE = 225;
	localparam int MAX_PRINTED     = 40;
	localparam int N_DIRECTED      = 16;

	typedef struct packed {
		logic [15:0] checksum;
		logic [15:0] seg_length;
		logic        too_long;
	} cksum_result_t;

	typedef struct {
		logic [15:0]   data_word;
		logic          single_byte;
		logic          last;
		logic [31:0]   src_ip;
		logic [31:0]   dst_ip;
		int            reps;
		bit            pinned;
		cksum_result_t want;
	} stim_row_t;

	typedef struct {
		bit            pinned;
		cksum_result_t want;
	} seg_hint_t;

	logic clk = 1'b0;
	logic arst_n;

	udpcs_in_if  pkt_if();
	udpcs_out_if res_if();

	udp_ipv4_checksum_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.res    (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A row with reps above one repeats its word; only the final copy may
	// carry last. Pinned rows carry a hand-computed result.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'hFFEC, 16'd2, 1'b0}},
		'{16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
			'{16'hFFEC, 16'd2, 1'b0}},
		'{16'hABCD, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'h54ED, 16'd1, 1'b0}},
		// The sum lands on 0xFFFF, so the checksum is a plain zero.
		'{16'hFFEC, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'h0000, 16'd2, 1'b0}},
		'{16'h0000, 1'b0, 1'b1, 32'h8000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'h7FEC, 16'd2, 1'b0}},
		'{16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h8000_0000, 1, 1'b1,
			'{16'h7FEC, 16'd2, 1'b0}},
		'{16'h4500, 1'b0, 1'b0, 32'hC0A8_0001, 32'hC0A8_00FE, 1, 1'b0, '0},
		// An odd byte in the middle of a segment.
		'{16'h1234, 1'b1, 1'b0, 32'hC0A8_0001, 32'hC0A8_00FE, 1, 1'b0, '0},
		'{16'hFFFF, 1'b0, 1'b0, 32'hC0A8_0001, 32'hC0A8_00FE, 3, 1'b0, '0},
		'{16'h8000, 1'b0, 1'b1, 32'hC0A8_0001, 32'hC0A8_00FE, 1, 1'b0, '0},
		// Exactly 65535 bytes: full length, no overflow.
		'{16'h0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32767, 1'b0, '0},
		'{16'h00FF, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'hFFEE, 16'hFFFF, 1'b0}},
		// 65536 bytes saturate the length.
		'{16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32768, 1'b1,
			'{16'hFFEE, 16'hFFFF, 1'b1}},
		'{16'hFFFF, 1'b0, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32800, 1'b0, '0},
		'{16'h5A5A, 1'b1, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 1'b0, '0},
		// State must be back at reset after a saturated segment.
		'{16'h0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1, 1'b1,
			'{16'hFFEC, 16'd2, 1'b0}}
	};

	cksum_result_t expected_sums[$];
	seg_hint_t     pending_hints[$];

	logic [15:0] acc_sum = 16'h0000;
	logic [15:0] acc_len = 16'h0000;
	logic        acc_ovf = 1'b0;

	int sender_idle_pct;
	int recv_stall_pct;
	int mismatches      = 0;
	int words_accepted  = 0;
	int segs_accepted   = 0;
	int results_checked = 0;
	int saturated_seen  = 0;
	int odd_length_seen = 0;
	int quiet_cycles    = 0;

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'b0, s[16]};
	endfunction

	// Folds one word into the running segment state; on the last word it adds
	// the pseudo-header and queues the checksum the engine should produce.
	function automatic void absorb_word(input logic [15:0] w, input logic one,
			input logic fin, input logic [31:0] src, input logic [31:0] dst);
		logic [15:0]   word;
		logic [16:0]   cnt;
		logic [15:0]   s;
		seg_hint_t     hint;
		cksum_result_t r;
		word = one ? (w & HIGH_BYTE_MASK) : w;
		acc_sum = oc_add(acc_sum, word);
		cnt = {1'b0, acc_len} + (one ? 17'd1 : 17'd2);
		if (cnt > {1'b0, LEN_MAX}) begin
			acc_len = LEN_MAX;
			acc_ovf = 1'b1;
		end else begin
			acc_len = cnt[15:0];
		end
		if (fin) begin
			s = acc_sum;
			s = oc_add(s, src[31:16]);
			s = oc_add(s, src[15:0]);
			s = oc_add(s, dst[31:16]);
			s = oc_add(s, dst[15:0]);
			s = oc_add(s, PROTO_UDP);
			s = oc_add(s, acc_len);
			r.checksum   = ~s;
			r.seg_length = acc_len;
			r.too_long   = acc_ovf;
			if (pending_hints.size() != 0) begin
				hint = pending_hints.pop_front();
				if (hint.pinned)
					r = hint.want;
			end
			expected_sums.push_back(r);
			acc_sum = 16'h0000;
			acc_len = 16'h0000;
			acc_ovf = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			absorb_word(pkt_if.data_word, pkt_if.single_byte, pkt_if.last,
				pkt_if.src_ip, pkt_if.dst_ip);
			words_accepted++;
			if (pkt_if.last)
				segs_accepted++;
		end
	end

	always @(posedge clk) begin
		cksum_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result checksum %h length %0d",
					res_if.checksum, res_if.seg_length));
			end else begin
				want = expected_sums.pop_front();
				if (res_if.checksum !== want.checksum)
					report_mismatch($sformatf("segment %0d checksum %h, expected %h",
						results_checked, res_if.checksum, want.checksum));
				if (res_if.seg_length !== want.seg_length)
					report_mismatch($sformatf("segment %0d seg_length %0d, expected %0d",
						results_checked, res_if.seg_length, want.seg_length));
				if (res_if.too_long !== want.too_long)
					report_mismatch($sformatf("segment %0d too_long %b, expected %b",
						results_checked, res_if.too_long, want.too_long));
			end
			if (res_if.too_long === 1'b1)
				saturated_seen++;
			if (res_if.seg_length[0] === 1'b1)
				odd_length_seen++;
			results_checked++;
		end
	end

	always @(posedge clk)
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [15:0] w, input logic one, input logic fin,
			input logic [31:0] src, input logic [31:0] dst,
			input bit pinned, input cksum_result_t want);
		seg_hint_t hint;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			pkt_if.valid <= 1'b0;
			@(posedge clk);
		end
		if (fin) begin
			hint.pinned = pinned;
			hint.want   = want;
			pending_hints.push_back(hint);
		end
		pkt_if.valid       <= 1'b1;
		pkt_if.data_word   <= w;
		pkt_if.single_byte <= one;
		pkt_if.last        <= fin;
		pkt_if.src_ip      <= src;
		pkt_if.dst_ip      <= dst;
		@(posedge clk);
		while (!pkt_if.ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every segment sent so far has its result.
	task automatic wait_for_results();
		pkt_if.valid <= 1'b0;
		@(posedge clk);
		while (results_checked != segs_accepted)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_segment(input int n_words, input int odd_per_mille);
		logic [15:0] w;
		logic        one;
		logic        fin;
		for (int i = 0; i < n_words; i++) begin
			fin = (i == n_words - 1);
			case ($urandom_range(7))
				0: w = 16'h0000;
				1: w = 16'hFFFF;
				default: w = 16'($urandom);
			endcase
			if (fin)
				one = 1'($urandom_range(1));
			else
				one = ($urandom_range(999) < odd_per_mille);
			send_word(w, one, fin, pick_addr(), pick_addr(), 1'b0, '0);
		end
	endtask

	initial begin
		int idle_mix  [4];
		int stall_mix [4];
		int phase_words;
		int n;
		int r;

		idle_mix  = '{0, 51, 0, 13};
		stall_mix = '{0, 0, 51, 13};
		sender_idle_pct = 13;
		recv_stall_pct  = 13;

		arst_n = 1'b0;
		pkt_if.valid       = 1'b0;
		pkt_if.data_word   = 16'h0000;
		pkt_if.single_byte = 1'b0;
		pkt_if.last        = 1'b0;
		pkt_if.src_ip      = 32'h0000_0000;
		pkt_if.dst_ip      = 32'h0000_0000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < N_DIRECTED; row++) begin
			for (int k = 0; k < directed_rows[row].reps; k++) begin
				send_word(directed_rows[row].data_word, directed_rows[row].single_byte,
					directed_rows[row].last && (k == directed_rows[row].reps - 1),
					directed_rows[row].src_ip, directed_rows[row].dst_ip,
					directed_rows[row].pinned, directed_rows[row].want);
			end
		end
		wait_for_results();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_mix[p];
			recv_stall_pct  = stall_mix[p];
			phase_words = 0;
			// One random segment long enough to run the length into saturation.
			if (p == 0)
				send_random_segment($urandom_range(32790, 32850), 1);
			while (phase_words < WORDS_PER_PHASE) begin
				r = $urandom_range(99);
				if (r < 60)
					n = $urandom_range(1, 4);
				else if (r < 90)
					n = $urandom_range(5, 24);
				else
					n = $urandom_range(25, 80);
				send_random_segment(n, 100);
				phase_words += n;
			end
			wait_for_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0)
			report_mismatch($sformatf("%0d checksums never delivered",
				expected_sums.size()));

		$display("Ran %0d segment words in %0d segments; %0d results saturated, %0d odd length.",
			words_accepted, results_checked, saturated_seen, odd_length_seen);
		$display("Directed extremes and zero checksum, then random segments under four idling mixes.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
